/* hw/rtl/wpbl_pkg.sv */
package wpbl_pkg;

  localparam logic [15:0] CHASSIS_LIMIT_RST  = 16'd16000;
  localparam logic [15:0] WARNING_ENERGY_RST = 16'd60;
  localparam logic [15:0] FAILSAFE_LIMIT_RST = 16'd6000;
  localparam logic [15:0] ERROR_TIMEOUT_RST  = 16'd100;

  localparam logic [1:0] REG_CHASSIS_LIMIT  = 2'd0;
  localparam logic [1:0] REG_WARNING_ENERGY = 2'd1;
  localparam logic [1:0] REG_FAILSAFE_LIMIT = 2'd2;
  localparam logic [1:0] REG_ERROR_TIMEOUT  = 2'd3;

  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  typedef struct packed {
    logic start;
    logic op;
  } wpbl_req_t;

endpackage

/* hw/rtl/wpbl_in_if.sv */
interface wpbl_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] wheel_cmd_0;
  logic signed [15:0] wheel_cmd_1;
  logic signed [15:0] wheel_cmd_2;
  logic signed [15:0] wheel_cmd_3;
  logic signed [15:0] gimbal_yaw_out;
  logic signed [15:0] gimbal_pitch_out;
  logic               judge_valid;
  logic        [15:0] remaining_energy;

  modport source (
    output valid, wheel_cmd_0, wheel_cmd_1, wheel_cmd_2, wheel_cmd_3,
           gimbal_yaw_out, gimbal_pitch_out, judge_valid, remaining_energy,
    input  ready
  );

  modport sink (
    input  valid, wheel_cmd_0, wheel_cmd_1, wheel_cmd_2, wheel_cmd_3,
           gimbal_yaw_out, gimbal_pitch_out, judge_valid, remaining_energy,
    output ready
  );
endinterface

/* hw/rtl/wpbl_out_if.sv */
interface wpbl_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] limited_cmd_0;
  logic signed [15:0] limited_cmd_1;
  logic signed [15:0] limited_cmd_2;
  logic signed [15:0] limited_cmd_3;
  logic        [15:0] budget_now;
  logic               was_scaled;

  modport source (
    output valid, limited_cmd_0, limited_cmd_1, limited_cmd_2, limited_cmd_3,
           budget_now, was_scaled,
    input  ready
  );

  modport sink (
    input  valid, limited_cmd_0, limited_cmd_1, limited_cmd_2, limited_cmd_3,
           budget_now, was_scaled,
    output ready
  );
endinterface

/* hw/rtl/wpbl_serial_unit.sv */
module wpbl_serial_unit import wpbl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  wpbl_req_t   req,
  input  logic [31:0] opa,
  input  logic [17:0] opb,
  output logic [31:0] result,
  output logic        done
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        op_r, op_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [17:0] hi_r, hi_nxt;
  logic [15:0] lo_r, lo_nxt;
  logic [17:0] opnd_r, opnd_nxt;

  logic [17:0] mul_sum;
  logic [18:0] div_trial;
  logic [18:0] div_diff;
  logic        div_ge;

  assign mul_sum   = {1'b0, hi_r[16:0]} + (lo_r[0] ? opnd_r : 18'd0);
  assign div_trial = {hi_r, lo_r[15]};
  assign div_diff  = div_trial - {1'b0, opnd_r};
  assign div_ge    = div_trial >= {1'b0, opnd_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    opnd_nxt = opnd_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 4'd0;
      op_nxt   = req.op;
      if (req.op == OP_DIV) begin
        hi_nxt   = {2'b00, opa[31:16]};
        lo_nxt   = opa[15:0];
        opnd_nxt = opb;
      end else begin
        hi_nxt   = 18'd0;
        lo_nxt   = opb[15:0];
        opnd_nxt = {2'b00, opa[15:0]};
      end
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 4'd1;
      if (op_r == OP_DIV) begin
        hi_nxt = div_ge ? div_diff[17:0] : div_trial[17:0];
        lo_nxt = {lo_r[14:0], div_ge};
      end else begin
        hi_nxt = {1'b0, mul_sum[17:1]};
        lo_nxt = {mul_sum[0], lo_r[15:1]};
      end
      if (cnt_r == 4'hF) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r   <= op_nxt;
    cnt_r  <= cnt_nxt;
    hi_r   <= hi_nxt;
    lo_r   <= lo_nxt;
    opnd_r <= opnd_nxt;
  end

  assign result = (op_r == OP_DIV) ? {16'd0, lo_r} : {hi_r[15:0], lo_r};
  assign done   = done_r;

endmodule

/* hw/rtl/wheel_power_budget_limiter_core.sv */
// Items go one at a time: a new one is accepted only in idle, once the last result
// is in the output register (the output waits while out_if.ready is low).
// Work runs on 16-step bit-serial units; a budget rebuilt from the energy ratio
// needs a divide and two multiplies in turn; four units then scale the wheels.
// Reset (synchronous, active low): registers to defaults, budget and counter to 0.
module wheel_power_budget_limiter_core import wpbl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  wpbl_in_if.sink     in_if,
  wpbl_out_if.source  out_if,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;
  localparam logic [3:0] S_RATIO  = 4'd2;
  localparam logic [3:0] S_SQ     = 4'd3;
  localparam logic [3:0] S_KD     = 4'd4;
  localparam logic [3:0] S_WSTART = 4'd5;
  localparam logic [3:0] S_WMUL   = 4'd6;
  localparam logic [3:0] S_WDIV   = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  localparam int NUM_UNITS = 5;

  function automatic logic [16:0] mag17(input logic [15:0] v);
    logic [16:0] ext;
    ext = {v[15], v};
    return v[15] ? (~ext + 17'd1) : ext;
  endfunction

  logic [3:0]  state_r, state_nxt;
  logic [15:0] chassis_r, warning_r, failsafe_r, timeout_r;
  logic [15:0] budget_r, budget_nxt;
  logic [15:0] inv_cnt_r, inv_cnt_nxt;

  logic [15:0] cmd_r [4];
  logic [15:0] cmd_nxt [4];
  logic [15:0] yaw_r, yaw_nxt, pitch_r, pitch_nxt;
  logic        jv_r, jv_nxt;
  logic [15:0] energy_r, energy_nxt;
  logic [17:0] sum_r, sum_nxt;
  logic [15:0] d_r, d_nxt;
  logic        scaled_r, scaled_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_cmd_r [4];
  logic [15:0] out_cmd_nxt [4];
  logic [15:0] out_budget_r, out_budget_nxt;
  logic        out_scaled_r, out_scaled_nxt;

  wpbl_req_t   req_u [NUM_UNITS];
  logic [31:0] opa_u [NUM_UNITS];
  logic [17:0] opb_u [NUM_UNITS];
  logic [31:0] res_u [NUM_UNITS];
  logic        done_u [NUM_UNITS];

  logic [16:0] mag_c [4];
  logic [17:0] sum_c;
  logic [16:0] gsum_c;
  logic [15:0] d_c;
  logic [15:0] cnt_inc;
  logic        cfg_wr;

  for (genvar g = 0; g < NUM_UNITS; g++) begin : g_unit
    wpbl_serial_unit u_unit (
      .clk    (clk),
      .rst_n  (rst_n),
      .req    (req_u[g]),
      .opa    (opa_u[g]),
      .opb    (opb_u[g]),
      .result (res_u[g]),
      .done   (done_u[g])
    );
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag_c[i] = mag17(cmd_r[i]);
    end
    sum_c   = 18'(mag_c[0]) + 18'(mag_c[1]) + 18'(mag_c[2]) + 18'(mag_c[3]);
    gsum_c  = mag17(yaw_r) + mag17(pitch_r);
    d_c     = ({1'b0, chassis_r} > gsum_c) ? 16'({1'b0, chassis_r} - gsum_c) : 16'd0;
    cnt_inc = (inv_cnt_r == 16'hFFFF) ? inv_cnt_r : inv_cnt_r + 16'd1;
  end

  always_comb begin
    state_nxt      = state_r;
    budget_nxt     = budget_r;
    inv_cnt_nxt    = inv_cnt_r;
    yaw_nxt        = yaw_r;
    pitch_nxt      = pitch_r;
    jv_nxt         = jv_r;
    energy_nxt     = energy_r;
    sum_nxt        = sum_r;
    d_nxt          = d_r;
    scaled_nxt     = scaled_r;
    out_budget_nxt = out_budget_r;
    out_scaled_nxt = out_scaled_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    for (int i = 0; i < 4; i++) begin
      cmd_nxt[i]     = cmd_r[i];
      out_cmd_nxt[i] = out_cmd_r[i];
    end
    for (int u = 0; u < NUM_UNITS; u++) begin
      req_u[u] = '{start: 1'b0, op: OP_MUL};
      opa_u[u] = 32'd0;
      opb_u[u] = 18'd0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          cmd_nxt[0] = in_if.wheel_cmd_0;
          cmd_nxt[1] = in_if.wheel_cmd_1;
          cmd_nxt[2] = in_if.wheel_cmd_2;
          cmd_nxt[3] = in_if.wheel_cmd_3;
          yaw_nxt    = in_if.gimbal_yaw_out;
          pitch_nxt  = in_if.gimbal_pitch_out;
          jv_nxt     = in_if.judge_valid;
          energy_nxt = in_if.remaining_energy;
          state_nxt  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        sum_nxt = sum_c;
        d_nxt   = d_c;
        if (jv_r) begin
          inv_cnt_nxt = 16'd0;
          if (energy_r >= warning_r) begin
            budget_nxt = chassis_r;
            state_nxt  = S_WSTART;
          end else begin
            req_u[0]  = '{start: 1'b1, op: OP_DIV};
            opa_u[0]  = {energy_r, 16'd0};
            opb_u[0]  = {2'b00, warning_r};
            state_nxt = S_RATIO;
          end
        end else begin
          inv_cnt_nxt = cnt_inc;
          if (cnt_inc > timeout_r) begin
            budget_nxt = failsafe_r;
          end
          state_nxt = S_WSTART;
        end
      end
      S_RATIO: begin
        if (done_u[0]) begin
          req_u[0]  = '{start: 1'b1, op: OP_MUL};
          opa_u[0]  = {16'd0, res_u[0][15:0]};
          opb_u[0]  = {2'b00, res_u[0][15:0]};
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        if (done_u[0]) begin
          req_u[0]  = '{start: 1'b1, op: OP_MUL};
          opa_u[0]  = {16'd0, res_u[0][31:16]};
          opb_u[0]  = {2'b00, d_r};
          state_nxt = S_KD;
        end
      end
      S_KD: begin
        if (done_u[0]) begin
          budget_nxt = res_u[0][31:16];
          state_nxt  = S_WSTART;
        end
      end
      S_WSTART: begin
        scaled_nxt = sum_r > {2'b00, budget_r};
        for (int i = 0; i < 4; i++) begin
          req_u[i+1] = '{start: 1'b1, op: OP_MUL};
          opa_u[i+1] = {16'd0, mag_c[i][15:0]};
          opb_u[i+1] = {2'b00, budget_r};
        end
        state_nxt = S_WMUL;
      end
      S_WMUL: begin
        if (done_u[1]) begin
          for (int i = 0; i < 4; i++) begin
            req_u[i+1] = '{start: 1'b1, op: OP_DIV};
            opa_u[i+1] = res_u[i+1];
            opb_u[i+1] = sum_r;
          end
          state_nxt = S_WDIV;
        end
      end
      S_WDIV: begin
        if (done_u[1]) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_if.ready) begin
          for (int i = 0; i < 4; i++) begin
            if (!scaled_r) begin
              out_cmd_nxt[i] = cmd_r[i];
            end else if (cmd_r[i][15]) begin
              out_cmd_nxt[i] = ~res_u[i+1][15:0] + 16'd1;
            end else begin
              out_cmd_nxt[i] = res_u[i+1][15:0];
            end
          end
          out_budget_nxt = budget_r;
          out_scaled_nxt = scaled_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      budget_r    <= 16'd0;
      inv_cnt_r   <= 16'd0;
      out_valid_r <= 1'b0;
      chassis_r   <= CHASSIS_LIMIT_RST;
      warning_r   <= WARNING_ENERGY_RST;
      failsafe_r  <= FAILSAFE_LIMIT_RST;
      timeout_r   <= ERROR_TIMEOUT_RST;
    end else begin
      state_r     <= state_nxt;
      budget_r    <= budget_nxt;
      inv_cnt_r   <= inv_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        case (cfg_paddr[3:2])
          REG_CHASSIS_LIMIT:  chassis_r  <= cfg_pwdata[15:0];
          REG_WARNING_ENERGY: warning_r  <= cfg_pwdata[15:0];
          REG_FAILSAFE_LIMIT: failsafe_r <= cfg_pwdata[15:0];
          REG_ERROR_TIMEOUT:  timeout_r  <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
    end
    for (int i = 0; i < 4; i++) begin
      cmd_r[i]     <= cmd_nxt[i];
      out_cmd_r[i] <= out_cmd_nxt[i];
    end
    yaw_r        <= yaw_nxt;
    pitch_r      <= pitch_nxt;
    jv_r         <= jv_nxt;
    energy_r     <= energy_nxt;
    sum_r        <= sum_nxt;
    d_r          <= d_nxt;
    scaled_r     <= scaled_nxt;
    out_budget_r <= out_budget_nxt;
    out_scaled_r <= out_scaled_nxt;
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_CHASSIS_LIMIT:  cfg_prdata = {16'd0, chassis_r};
      REG_WARNING_ENERGY: cfg_prdata = {16'd0, warning_r};
      REG_FAILSAFE_LIMIT: cfg_prdata = {16'd0, failsafe_r};
      REG_ERROR_TIMEOUT:  cfg_prdata = {16'd0, timeout_r};
      default:            cfg_prdata = 32'd0;
    endcase
  end

  assign cfg_pready = 1'b1;

  assign in_if.ready          = (state_r == S_IDLE);
  assign out_if.valid         = out_valid_r;
  assign out_if.limited_cmd_0 = out_cmd_r[0];
  assign out_if.limited_cmd_1 = out_cmd_r[1];
  assign out_if.limited_cmd_2 = out_cmd_r[2];
  assign out_if.limited_cmd_3 = out_cmd_r[3];
  assign out_if.budget_now    = out_budget_r;
  assign out_if.was_scaled    = out_scaled_r;

endmodule
